### rtl/core/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants for the go-to-goal drive controller
// Fixed-point constants, CORDIC arctangent table, command and phase codes.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int TableLen           = 24;

    localparam logic [1:0] CMD_POSE = 2'd0;
    localparam logic [1:0] CMD_GOAL = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] PH_DRIVE = 2'd0;
    localparam logic [1:0] PH_TURN  = 2'd1;
    localparam logic [1:0] PH_HOLD  = 2'd2;

    localparam logic [2:0] REG_LIN_GAIN   = 3'd0;
    localparam logic [2:0] REG_STEER_GAIN = 3'd1;
    localparam logic [2:0] REG_TURN_GAIN  = 3'd2;
    localparam logic [2:0] REG_LIN_LIMIT  = 3'd3;
    localparam logic [2:0] REG_ANG_LIMIT  = 3'd4;
    localparam logic [2:0] REG_DIST_TOL   = 3'd5;
    localparam logic [2:0] REG_HEAD_TOL   = 3'd6;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] ONE_Q30      = 32'd1073741824;
    localparam logic signed [51:0] HALF_PI_Q30 = 52'sd1686629713;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
        logic [1:0]         phase;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] linear_gain;
        logic [15:0] steer_gain;
        logic [15:0] final_turn_gain;
        logic [14:0] linear_limit;
        logic [14:0] angular_limit;
        logic [30:0] distance_tolerance;
        logic [14:0] yaw_band;
    } t_cfg;

    // CORDIC control bundle between sequencer and datapath
    typedef struct packed {
        logic       load_vec;  // load dx,dy into vectoring mode
        logic       load_rot;  // load angle into rotation mode
        logic       step;      // one micro-rotation
        logic [4:0] idx;       // iteration index
    } t_cordic_ctl;

    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 31'd843314857;
            5'd1:  atan_q30 = 31'd497837829;
            5'd2:  atan_q30 = 31'd263043837;
            5'd3:  atan_q30 = 31'd133525159;
            5'd4:  atan_q30 = 31'd67021687;
            5'd5:  atan_q30 = 31'd33543516;
            5'd6:  atan_q30 = 31'd16775851;
            5'd7:  atan_q30 = 31'd8388437;
            5'd8:  atan_q30 = 31'd4194283;
            5'd9:  atan_q30 = 31'd2097149;
            5'd10: atan_q30 = 31'd1048576;
            5'd11: atan_q30 = 31'd524288;
            5'd12: atan_q30 = 31'd262144;
            5'd13: atan_q30 = 31'd131072;
            5'd14: atan_q30 = 31'd65536;
            5'd15: atan_q30 = 31'd32768;
            5'd16: atan_q30 = 31'd16384;
            5'd17: atan_q30 = 31'd8192;
            5'd18: atan_q30 = 31'd4096;
            5'd19: atan_q30 = 31'd2048;
            5'd20: atan_q30 = 31'd1024;
            5'd21: atan_q30 = 31'd512;
            5'd22: atan_q30 = 31'd256;
            5'd23: atan_q30 = 31'd128;
            default: atan_q30 = 31'd0;
        endcase
    endfunction

endpackage

### rtl/core/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic: shared CORDIC micro-rotation unit
// Vectoring (y to 0) or rotation (z to 0); one iteration per cycle with step.
// ----------------------------------------------------------------------------
module gtg_cordic (
    input  logic                    i_clk,
    input  gtg_pkg::t_cordic_ctl    i_ctl,
    input  logic signed [32:0]      i_dx,
    input  logic signed [32:0]      i_dy,
    input  logic signed [15:0]      i_angle,
    output logic signed [51:0]      o_x,
    output logic signed [51:0]      o_z
);
    // 33-bit offset plus 16 guard bits, plus CORDIC growth
    logic signed [51:0] r_x, r_y, r_z;
    logic signed [51:0] n_x, n_y, n_z;
    logic               r_vec;
    logic signed [51:0] w_dxg, w_dyg, w_xs, w_ys, w_at;
    logic               w_pos;

    assign w_dxg = {{3{i_dx[32]}}, i_dx, 16'd0};
    assign w_dyg = {{3{i_dy[32]}}, i_dy, 16'd0};
    assign w_xs  = r_x >>> i_ctl.idx;
    assign w_ys  = r_y >>> i_ctl.idx;
    assign w_at  = {21'd0, gtg_pkg::atan_q30(i_ctl.idx)};
    assign w_pos = r_vec ? (r_y > 0) : (r_z >= 0);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_ctl.load_vec) begin
            if (i_dx[32] && !i_dy[32]) begin
                n_x = w_dyg;
                n_y = -w_dxg;
                n_z = gtg_pkg::HALF_PI_Q30;
            end else if (i_dx[32]) begin
                n_x = -w_dyg;
                n_y = w_dxg;
                n_z = -gtg_pkg::HALF_PI_Q30;
            end else begin
                n_x = w_dxg;
                n_y = w_dyg;
                n_z = '0;
            end
        end else if (i_ctl.load_rot) begin
            n_x = {20'd0, gtg_pkg::INV_GAIN_Q30};
            n_y = '0;
            n_z = {{19{i_angle[15]}}, i_angle, 17'd0};
        end else if (i_ctl.step) begin
            if (w_pos) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_at;
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_at;
            end
            if (r_vec) begin
                // vectoring rotates the other way
                if (w_pos) begin
                    n_x = r_x + w_ys;
                    n_y = r_y - w_xs;
                    n_z = r_z + w_at;
                end else begin
                    n_x = r_x - w_ys;
                    n_y = r_y + w_xs;
                    n_z = r_z - w_at;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (i_ctl.load_vec) begin
            r_vec <= 1'b1;
        end else if (i_ctl.load_rot) begin
            r_vec <= 1'b0;
        end
    end

    assign o_x = r_x;
    assign o_z = r_z;
endmodule

### rtl/core/go_to_goal_drive_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_drive_controller: differential-drive go-to-goal P controller
// Stores pose and goal, answers each control tick with a velocity command.
// ----------------------------------------------------------------------------
// Pose and goal beats are stored when accepted and give no result. A control
// tick, once both pose and goal are held, runs one shared CORDIC unit
// twice: CORDIC_STEPS vectoring iterations for distance and bearing, then
// CORDIC_STEPS rotation iterations for the cosine of the heading error,
// with load, wrap, scaling and multiply steps around them (CORDIC_STEPS
// is capped at 24). o_in_stall is high for the whole run; unless the
// receiver stalls, the next beat can be accepted in the cycle the result
// becomes valid. The result sits in an output register until taken; while
// it waits under a receiver stall, o_in_stall stays high and the next
// tick's result is held back likewise. Config writes are taken at any time
// (ready is always high) and must only be issued while the block is idle.
module go_to_goal_drive_controller #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gtg_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gtg_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int NSteps = (CORDIC_STEPS > gtg_pkg::TableLen) ? gtg_pkg::TableLen
                                                              : CORDIC_STEPS;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VLOAD = 4'd1;
    localparam logic [3:0] S_VEC   = 4'd2;
    localparam logic [3:0] S_MAG   = 4'd3;
    localparam logic [3:0] S_DIST  = 4'd4;
    localparam logic [3:0] S_WRAP  = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_ROT   = 4'd7;
    localparam logic [3:0] S_LIN1  = 4'd8;
    localparam logic [3:0] S_LIN2  = 4'd9;
    localparam logic [3:0] S_ANG   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    gtg_pkg::t_cfg r_cfg;
    logic signed [31:0] r_rx, r_ry, r_tx, r_ty;
    logic signed [15:0] r_rh, r_th;
    logic r_pose_ok, r_goal_ok;
    logic [3:0] r_state;
    logic [4:0] r_idx;
    logic r_out_valid;
    gtg_pkg::t_out_beat r_out;

    logic [35:0]        r_mag;   // floored magnitude
    logic [32:0]        r_dist;  // Q16.16 distance, up to sqrt(2) * 2^32
    logic signed [17:0] r_err, r_ferr;
    logic signed [15:0] r_bear;
    logic [47:0]        r_lin;
    logic               r_drive, r_turn;
    logic [24:0]        r_cos;

    gtg_pkg::t_cordic_ctl w_ctl;
    logic signed [51:0] w_cx, w_cz;
    logic w_in_acc, w_out_acc, w_busy;

    assign w_busy     = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_in_stall = w_busy;
    assign w_in_acc   = i_in_valid && !w_busy;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_ctl = '0;
        w_ctl.idx = r_idx;
        w_ctl.load_vec = (r_state == S_VLOAD);
        w_ctl.load_rot = (r_state == S_DEC);
        w_ctl.step     = (r_state == S_VEC) || (r_state == S_ROT);
    end

    gtg_cordic u_cordic (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_dx   (33'(r_tx) - 33'(r_rx)),
        .i_dy   (33'(r_ty) - 33'(r_ry)),
        .i_angle(r_err[15:0]),
        .o_x    (w_cx),
        .o_z    (w_cz)
    );

    // one wrap step per use; values stay within a couple of turns
    function automatic logic signed [17:0] wrap1(input logic signed [17:0] a);
        if (a > gtg_pkg::PI_Q13) begin
            wrap1 = a - gtg_pkg::TWO_PI_Q13;
        end else if (a < -gtg_pkg::PI_Q13) begin
            wrap1 = a + gtg_pkg::TWO_PI_Q13;
        end else begin
            wrap1 = a;
        end
    endfunction

    function automatic logic signed [15:0] turn(input logic [15:0] g,
                                               input logic signed [17:0] e,
                                               input logic [14:0] lim);
        logic signed [35:0] p;
        logic signed [22:0] v;
        p = $signed({1'b0, g}) * e + 36'sd4096;
        v = 23'(p >>> 13);
        if (v > $signed({8'd0, lim})) begin
            turn = $signed({1'b0, lim});
        end else if (v < -$signed({8'd0, lim})) begin
            turn = -$signed({1'b0, lim});
        end else begin
            turn = v[15:0];
        end
    endfunction

    logic [63:0] w_mprod;
    logic signed [51:0] w_zr;
    logic [17:0] w_fabs;
    assign w_mprod = 64'(r_mag) * 64'(gtg_pkg::INV_GAIN_Q30);
    assign w_zr    = (w_cz + 52'sd65536) >>> 17;
    assign w_fabs  = r_ferr[17] ? 18'(-r_ferr) : 18'(r_ferr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_gain        <= 16'd3277;
            r_cfg.steer_gain         <= 16'd7373;
            r_cfg.final_turn_gain    <= 16'd4915;
            r_cfg.linear_limit       <= 15'd2458;
            r_cfg.angular_limit      <= 15'd6144;
            r_cfg.distance_tolerance <= 31'd5243;
            r_cfg.yaw_band           <= 15'd410;
            r_rx <= '0; r_ry <= '0; r_tx <= '0; r_ty <= '0;
            r_rh <= '0; r_th <= '0;
            r_pose_ok <= 1'b0;
            r_goal_ok <= 1'b0;
            r_state <= S_IDLE;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gtg_pkg::REG_LIN_GAIN:   r_cfg.linear_gain <= i_cfg_data[15:0];
                    gtg_pkg::REG_STEER_GAIN: r_cfg.steer_gain <= i_cfg_data[15:0];
                    gtg_pkg::REG_TURN_GAIN:  r_cfg.final_turn_gain <= i_cfg_data[15:0];
                    gtg_pkg::REG_LIN_LIMIT:  r_cfg.linear_limit <= i_cfg_data[14:0];
                    gtg_pkg::REG_ANG_LIMIT:  r_cfg.angular_limit <= i_cfg_data[14:0];
                    gtg_pkg::REG_DIST_TOL:   r_cfg.distance_tolerance <= i_cfg_data[30:0];
                    gtg_pkg::REG_HEAD_TOL:   r_cfg.yaw_band <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            // new result replaces a taken one in the same cycle
            if (r_state == S_DONE && (!r_out_valid || w_out_acc)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in_data.command)
                            gtg_pkg::CMD_POSE: begin
                                r_rx <= i_in_data.pos_x;
                                r_ry <= i_in_data.pos_y;
                                r_rh <= i_in_data.heading;
                                r_pose_ok <= 1'b1;
                            end
                            gtg_pkg::CMD_GOAL: begin
                                r_tx <= i_in_data.pos_x;
                                r_ty <= i_in_data.pos_y;
                                r_th <= i_in_data.heading;
                                r_goal_ok <= 1'b1;
                            end
                            gtg_pkg::CMD_TICK: begin
                                if (r_pose_ok && r_goal_ok) begin
                                    r_state <= S_VLOAD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_VLOAD: begin
                    r_idx <= '0;
                    r_state <= S_VEC;
                end
                S_VEC: begin
                    r_idx <= r_idx + 5'd1;
                    if (r_idx == 5'(NSteps - 1)) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_mag  <= w_cx[51] ? '0 : w_cx[51:16];
                    r_bear <= w_zr[15:0];
                    r_ferr <= 18'(r_th) - 18'(r_rh);
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_dist <= 33'((w_mprod + 64'd536870912) >> 30);
                    r_err  <= 18'(r_bear) - 18'(r_rh);
                    r_ferr <= wrap1(r_ferr);
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    r_err  <= wrap1(r_err);
                    r_ferr <= wrap1(r_ferr);
                    r_drive <= (r_dist > {2'b0, r_cfg.distance_tolerance});
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_err  <= wrap1(r_err);
                    r_turn <= (w_fabs > 18'(r_cfg.yaw_band));
                    r_idx  <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_idx <= r_idx + 5'd1;
                    if (r_idx == 5'(NSteps - 1)) begin
                        r_state <= S_LIN1;
                    end
                end
                S_LIN1: begin
                    if (r_err >= gtg_pkg::HALF_PI_Q13 || r_err <= -gtg_pkg::HALF_PI_Q13
                        || w_cx[51]) begin
                        r_cos <= '0;
                    end else if (w_cx > $signed({20'd0, gtg_pkg::ONE_Q30})) begin
                        r_cos <= 25'd16777216;
                    end else begin
                        r_cos <= w_cx[30:6];
                    end
                    r_lin <= 48'((64'(r_cfg.linear_gain) * 64'(r_dist)) >> 16);
                    r_state <= S_LIN2;
                end
                S_LIN2: begin
                    r_lin <= 48'((64'(r_lin[32:0]) * 64'(r_cos)) >> 24);
                    r_state <= S_ANG;
                end
                S_ANG: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || w_out_acc) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result assembly; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || w_out_acc)) begin
            if (r_drive) begin
                r_out.linear_velocity <= (r_lin > 48'(r_cfg.linear_limit))
                    ? $signed({1'b0, r_cfg.linear_limit}) : $signed(r_lin[15:0]);
                r_out.angular_velocity <= turn(r_cfg.steer_gain, r_err,
                                               r_cfg.angular_limit);
                r_out.phase <= gtg_pkg::PH_DRIVE;
            end else if (r_turn) begin
                r_out.linear_velocity <= '0;
                r_out.angular_velocity <= turn(r_cfg.final_turn_gain, r_ferr,
                                               r_cfg.angular_limit);
                r_out.phase <= gtg_pkg::PH_TURN;
            end else begin
                r_out.linear_velocity <= '0;
                r_out.angular_velocity <= '0;
                r_out.phase <= gtg_pkg::PH_HOLD;
            end
        end
    end

    // a result only appears at the end of a run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result without a run");
    // no beat accepted while computing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("beat accepted mid run");
    // phase code is valid whenever a result is shown
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.phase != 2'd3))
        else $error("bad phase");
endmodule
